>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock edge, switched off while reset is high.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, prop, msg) \
  `ASSERT_SYNC(lbl, clk, rst, !(prop), msg)

`endif

>>> rtl/pcoc_pkg.sv
// Shared types and constants of the phase current offset calibrator.
package pcoc_pkg;

  localparam int DT_W       = 12;
  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

  localparam logic [REG_W-1:0] ALIGN_RESET  = 16'd5000;
  localparam logic [REG_W-1:0] TARGET_RESET = 16'd2048;

  localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  // Control of one serial lane: load a sample, run an add step or a divide step.
  typedef struct packed {
    logic load;
    logic acc;
    logic div;
  } lane_ctl_t;

endpackage

>>> rtl/pcoc_lane.sv
// One phase lane: bit-serial accumulator and bit-serial restoring divider.
module pcoc_lane #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pcoc_pkg::lane_ctl_t   ctl,
  input  logic [ADC_BITS-1:0]   sample,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [ADC_BITS-1:0]   quotient
);
  import pcoc_pkg::*;

  localparam int SUM_W = ADC_BITS + COUNT_BITS;

  logic [SUM_W-1:0]      sum;
  logic [ADC_BITS-1:0]   addend;
  logic                  carry;
  logic [COUNT_BITS-1:0] rem;
  logic [ADC_BITS-1:0]   quo;

  logic                  sum_bit;
  logic                  carry_next;
  logic [COUNT_BITS:0]   trial;
  logic                  take;
  logic [COUNT_BITS:0]   diff;
  logic [COUNT_BITS-1:0] rem_next;

  // Full adder on the low bits; the sum word rotates right, LSB first.
  assign sum_bit    = sum[0] ^ addend[0] ^ carry;
  assign carry_next = (sum[0] & addend[0]) | (sum[0] & carry) | (addend[0] & carry);

  // Restoring division step: bring in the next dividend bit, MSB first.
  assign trial    = {rem, sum[SUM_W-1]};
  assign take     = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = take ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      carry <= 1'b0;
      rem   <= '0;
      quo   <= '0;
    end else if (ctl.load) begin
      carry <= 1'b0;
      rem   <= '0;
    end else if (ctl.acc) begin
      sum   <= {sum_bit, sum[SUM_W-1:1]};
      carry <= carry_next;
    end else if (ctl.div) begin
      sum <= {sum[SUM_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[ADC_BITS-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addend <= sample;
    end else if (ctl.acc) begin
      addend <= {1'b0, addend[ADC_BITS-1:1]};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/phase_current_offset_calibrator.sv
// Top level of the phase current offset calibrator: sequencer, registers and lanes.
//
//  Channel | Direction | Handshake           | Content
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid / in_stall | tick_dt_us, adc_phase_a/b/c
//  out     | output    | out_valid/out_stall | status, bridge, zero voltage, offsets
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (write only)
//
// Idle, align, done and error ticks go from the transfer straight to their push.
// A sampling tick or the processing tick first runs the bit-serial add or divide
// in the three lanes, and only then pushes its result to the output.
// One tick is in flight at a time; a tick is taken while an earlier result
// still waits on the output, and the next one once that result has moved on.
// Reset is synchronous and returns the sequencer to its idle phase with the
// registers at their defaults; cfg_ready is always high.
module phase_current_offset_calibrator #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pcoc_pkg::DT_W-1:0]      tick_dt_us,
  input  logic [ADC_BITS-1:0]            adc_phase_a,
  input  logic [ADC_BITS-1:0]            adc_phase_b,
  input  logic [ADC_BITS-1:0]            adc_phase_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pcoc_pkg::STATUS_W-1:0]  calib_status,
  output logic                           bridge_enable,
  output logic                           force_zero_voltage,
  output logic                           offset_valid,
  output logic [ADC_BITS-1:0]            offset_phase_a,
  output logic [ADC_BITS-1:0]            offset_phase_b,
  output logic [ADC_BITS-1:0]            offset_phase_c,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcoc_pkg::REG_W-1:0]     cfg_data
);
  import pcoc_pkg::*;

  localparam int SUM_W  = ADC_BITS + COUNT_BITS;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int CMP_W  = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [REG_W-1:0]      TIMER_MAX = {REG_W{1'b1}};

  // Calibration phases, advanced at most once per tick.
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_ALIGN      = 3'd1,
    PH_SAMPLING   = 3'd2,
    PH_PROCESSING = 3'd3,
    PH_DONE       = 3'd4,
    PH_ERROR      = 3'd5
  } phase_t;

  // Sequencer states within one tick.
  typedef enum logic [1:0] {
    C_READY,
    C_ACC,
    C_DIV,
    C_PUSH
  } ctrl_t;

  ctrl_t                 cstate;
  phase_t                ph;
  logic [REG_W-1:0]      timer;
  logic [COUNT_BITS-1:0] cnt;
  logic [STEP_W-1:0]     step;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_bridge;
  logic                  res_zero;
  logic                  res_valid;

  logic [REG_W-1:0]      align_time_us;
  logic [REG_W-1:0]      sample_count_target;

  logic                  accept;
  logic [REG_W:0]        timer_sum;
  logic [REG_W-1:0]      timer_next;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  sampling_over;
  lane_ctl_t             lane_ctl;
  logic [ADC_BITS-1:0]   quo_a;
  logic [ADC_BITS-1:0]   quo_b;
  logic [ADC_BITS-1:0]   quo_c;

  assign in_stall  = (cstate != C_READY);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The settling timer saturates at its full scale, so the longest align
  // time is still reached.
  assign timer_sum  = {1'b0, timer} + (REG_W + 1)'(tick_dt_us);
  assign timer_next = timer_sum[REG_W] ? TIMER_MAX : timer_sum[REG_W-1:0];

  // The sample is counted before the compare, so a target of zero acts as one.
  // The count stops at its full scale, which also ends sampling.
  assign cnt_next      = (cnt != COUNT_MAX) ? cnt + 1'b1 : cnt;
  assign sampling_over = (CMP_W'(cnt_next) >= CMP_W'(sample_count_target)) ||
                         (cnt_next == COUNT_MAX);

  // The lanes load on the transfer of a sampling tick, or of the processing
  // tick when there is something to divide, then step once per cycle.
  always_comb begin
    lane_ctl.load = accept &&
                    ((ph == PH_SAMPLING) || ((ph == PH_PROCESSING) && (cnt != '0)));
    lane_ctl.acc  = (cstate == C_ACC);
    lane_ctl.div  = (cstate == C_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      align_time_us       <= ALIGN_RESET;
      sample_count_target <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALIGN:  align_time_us       <= cfg_data;
        CFG_TARGET: sample_count_target <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate         <= C_READY;
      ph             <= PH_IDLE;
      timer          <= '0;
      cnt            <= '0;
      step           <= '0;
      res_status     <= ST_BUSY;
      res_bridge     <= 1'b0;
      res_zero       <= 1'b0;
      res_valid      <= 1'b0;
      out_valid      <= 1'b0;
      offset_phase_a <= '0;
      offset_phase_b <= '0;
      offset_phase_c <= '0;
    end else begin
      // A result that moves on is cleared here, unless the push below
      // replaces it with the next one in the same cycle.
      if (out_valid && !out_stall && (cstate != C_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (cstate)
        C_READY: begin
          if (accept) begin
            res_status <= ST_BUSY;
            res_bridge <= 1'b0;
            res_zero   <= 1'b0;
            res_valid  <= 1'b0;
            cstate     <= C_PUSH;
            case (ph)
              PH_IDLE: begin
                ph         <= PH_ALIGN;
                res_bridge <= 1'b1;
              end
              PH_ALIGN: begin
                timer      <= timer_next;
                res_zero   <= 1'b1;
                res_bridge <= 1'b1;
                if (timer_next >= align_time_us) begin
                  ph <= PH_SAMPLING;
                end
              end
              PH_SAMPLING: begin
                cnt        <= cnt_next;
                res_bridge <= 1'b1;
                step       <= STEP_W'(SUM_W - 1);
                cstate     <= C_ACC;
                if (sampling_over) begin
                  ph <= PH_PROCESSING;
                end
              end
              PH_PROCESSING: begin
                // An empty count cannot occur in a normal run; it is
                // reported as an error from the next tick on.
                if (cnt == '0) begin
                  ph <= PH_ERROR;
                end else begin
                  ph        <= PH_DONE;
                  res_valid <= 1'b1;
                  step      <= STEP_W'(SUM_W - 1);
                  cstate    <= C_DIV;
                end
              end
              PH_DONE: begin
                res_status <= ST_DONE;
              end
              default: begin
                ph         <= PH_ERROR;
                res_status <= ST_ERROR;
              end
            endcase
          end
        end
        C_ACC, C_DIV: begin
          if (step == '0) begin
            cstate <= C_PUSH;
          end else begin
            step <= step - 1'b1;
          end
        end
        C_PUSH: begin
          // The offsets shown are those held in the lanes: zero until the
          // division has run, and the last quotient after it.
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            calib_status       <= res_status;
            bridge_enable      <= res_bridge;
            force_zero_voltage <= res_zero;
            offset_valid       <= res_valid;
            offset_phase_a     <= quo_a;
            offset_phase_b     <= quo_b;
            offset_phase_c     <= quo_c;
            cstate             <= C_READY;
          end
        end
        default: cstate <= C_READY;
      endcase
    end
  end

  pcoc_lane #(.ADC_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_lane_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .sample   (adc_phase_a),
    .divisor  (cnt),
    .quotient (quo_a)
  );

  pcoc_lane #(.ADC_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .sample   (adc_phase_b),
    .divisor  (cnt),
    .quotient (quo_b)
  );

  pcoc_lane #(.ADC_BITS(ADC_BITS), .COUNT_BITS(COUNT_BITS)) u_lane_c (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .sample   (adc_phase_c),
    .divisor  (cnt),
    .quotient (quo_c)
  );

endmodule

>>> rtl/pcoc_checker.sv
// Port-level checker of the phase current offset calibrator and its bind.
`include "assert_macros.svh"

module pcoc_checker #(
  parameter int ADC_BITS = 12
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pcoc_pkg::STATUS_W-1:0]  calib_status,
  input logic                           bridge_enable,
  input logic                           force_zero_voltage,
  input logic                           offset_valid,
  input logic [ADC_BITS-1:0]            offset_phase_a,
  input logic [ADC_BITS-1:0]            offset_phase_b,
  input logic [ADC_BITS-1:0]            offset_phase_c
);
  import pcoc_pkg::*;

  // The tick that produces the offsets switches the bridge off and is still busy.
  `ASSERT_SYNC(a_offset_tick, clk, rst, (out_valid && offset_valid) |-> (!bridge_enable && (calib_status == ST_BUSY)), "offset tick with bridge on or wrong status")

  // Once done, the bridge stays off and no zero voltage is commanded.
  `ASSERT_SYNC(a_done_quiet, clk, rst, (out_valid && (calib_status == ST_DONE)) |-> (!bridge_enable && !force_zero_voltage && !offset_valid), "done tick with bridge or offsets active")

  // Zero voltage is only commanded while the bridge is enabled.
  `ASSERT_SYNC(a_zero_needs_bridge, clk, rst, (out_valid && force_zero_voltage) |-> bridge_enable, "zero voltage with bridge off")

  // The unused status code never appears.
  `ASSERT_NEVER(a_status_code, clk, rst, out_valid && (calib_status != ST_BUSY) && (calib_status != ST_DONE) && (calib_status != ST_ERROR), "undefined status code")

  // A stalled result holds its offsets.
  `ASSERT_SYNC(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(offset_phase_a) && $stable(offset_phase_b) && $stable(offset_phase_c)), "stalled result changed")

endmodule

bind phase_current_offset_calibrator pcoc_checker #(.ADC_BITS(ADC_BITS)) u_pcoc_checker (.*);
